### design/acs_pkg.sv
// Package for the Arabic contextual shaper: word types, letter form table, mark set.
// No dependencies.
`default_nettype none
package acs_pkg;

  localparam int unsigned MarkQueueDepthDefault = 16;
  localparam int unsigned LetterCount = 43;
  localparam logic [5:0] NoLetter = 6'd63;

  typedef struct packed {
    logic [15:0] code_point;
    logic        end_of_text;
  } in_word_t;

  typedef struct packed {
    logic [15:0] shaped_code;
    logic        last_of_run;
  } out_word_t;

  // Isolated, initial, medial, final forms of one letter.
  typedef struct packed {
    logic [15:0] iso;
    logic [15:0] ini;
    logic [15:0] med;
    logic [15:0] fin;
  } forms_t;

  // Output source select.
  typedef enum logic [1:0] {
    SRC_LETTER = 2'd0,
    SRC_MARK   = 2'd1,
    SRC_INPUT  = 2'd2
  } src_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       capture;     // latch the accepted word and classify it
    logic       enqueue;     // push the captured mark
    logic       hold_letter; // captured letter becomes the held letter
    logic       clear_held;  // held letter and marks are gone
    logic       rd_start;    // reset mark read pointer
    logic       rd_next;     // advance mark read pointer
    logic       after_join;  // the following character joins backward
    logic       prior_clear; // break joining
    logic       eot_clear;   // end-of-text context clear
    logic       emit;        // load output register
    src_e       src;
    logic       last;
  } ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_letter;
    logic is_mark;
    logic eot;
    logic held_valid;
    logic queue_full;
    logic marks_left;   // read pointer below mark count
    logic marks_one;    // exactly one mark left to read
    logic joins_bwd;    // captured letter joins backward
  } stat_t;

  function automatic logic [5:0] letter_row(input logic [15:0] cp);
    logic [5:0] r;
    r = NoLetter;
    case (cp)
      16'h0621: r = 6'd0;  16'h0622: r = 6'd1;  16'h0623: r = 6'd2;
      16'h0624: r = 6'd3;  16'h0625: r = 6'd4;  16'h0626: r = 6'd5;
      16'h0627: r = 6'd6;  16'h0628: r = 6'd7;  16'h0629: r = 6'd8;
      16'h062A: r = 6'd9;  16'h062B: r = 6'd10; 16'h062C: r = 6'd11;
      16'h062D: r = 6'd12; 16'h062E: r = 6'd13; 16'h062F: r = 6'd14;
      16'h0630: r = 6'd15; 16'h0631: r = 6'd16; 16'h0632: r = 6'd17;
      16'h0698: r = 6'd18; 16'h0633: r = 6'd19; 16'h0634: r = 6'd20;
      16'h0635: r = 6'd21; 16'h0636: r = 6'd22; 16'h0637: r = 6'd23;
      16'h0638: r = 6'd24; 16'h0639: r = 6'd25; 16'h063A: r = 6'd26;
      16'h0640: r = 6'd27; 16'h0641: r = 6'd28; 16'h0642: r = 6'd29;
      16'h0643: r = 6'd30; 16'h0644: r = 6'd31; 16'h0645: r = 6'd32;
      16'h0646: r = 6'd33; 16'h0647: r = 6'd34; 16'h0648: r = 6'd35;
      16'h0649: r = 6'd36; 16'h064A: r = 6'd37; 16'h06CC: r = 6'd38;
      16'h0686: r = 6'd39; 16'h067E: r = 6'd40; 16'h06AF: r = 6'd41;
      16'h06A9: r = 6'd42;
      default:  r = NoLetter;
    endcase
    return r;
  endfunction

  function automatic forms_t letter_forms(input logic [5:0] r);
    forms_t f;
    f = '0;
    case (r)
      6'd0:  f = '{16'hFE80, 16'h0000, 16'h0000, 16'h0000};
      6'd1:  f = '{16'hFE81, 16'h0000, 16'h0000, 16'hFE82};
      6'd2:  f = '{16'hFE83, 16'h0000, 16'h0000, 16'hFE84};
      6'd3:  f = '{16'hFE85, 16'h0000, 16'h0000, 16'hFE86};
      6'd4:  f = '{16'hFE87, 16'h0000, 16'h0000, 16'hFE88};
      6'd5:  f = '{16'hFE89, 16'hFE8B, 16'hFE8C, 16'hFE8A};
      6'd6:  f = '{16'hFE8D, 16'h0000, 16'h0000, 16'hFE8E};
      6'd7:  f = '{16'hFE8F, 16'hFE91, 16'hFE92, 16'hFE90};
      6'd8:  f = '{16'hFE93, 16'h0000, 16'h0000, 16'hFE94};
      6'd9:  f = '{16'hFE95, 16'hFE97, 16'hFE98, 16'hFE96};
      6'd10: f = '{16'hFE99, 16'hFE9B, 16'hFE9C, 16'hFE9A};
      6'd11: f = '{16'hFE9D, 16'hFE9F, 16'hFEA0, 16'hFE9E};
      6'd12: f = '{16'hFEA1, 16'hFEA3, 16'hFEA4, 16'hFEA2};
      6'd13: f = '{16'hFEA5, 16'hFEA7, 16'hFEA8, 16'hFEA6};
      6'd14: f = '{16'hFEA9, 16'h0000, 16'h0000, 16'hFEAA};
      6'd15: f = '{16'hFEAB, 16'h0000, 16'h0000, 16'hFEAC};
      6'd16: f = '{16'hFEAD, 16'h0000, 16'h0000, 16'hFEAE};
      6'd17: f = '{16'hFEAF, 16'h0000, 16'h0000, 16'hFEB0};
      6'd18: f = '{16'hFB8A, 16'h0000, 16'h0000, 16'hFB8B};
      6'd19: f = '{16'hFEB1, 16'hFEB3, 16'hFEB4, 16'hFEB2};
      6'd20: f = '{16'hFEB5, 16'hFEB7, 16'hFEB8, 16'hFEB6};
      6'd21: f = '{16'hFEB9, 16'hFEBB, 16'hFEBC, 16'hFEBA};
      6'd22: f = '{16'hFEBD, 16'hFEBF, 16'hFEC0, 16'hFEBE};
      6'd23: f = '{16'hFEC1, 16'hFEC3, 16'hFEC4, 16'hFEC2};
      6'd24: f = '{16'hFEC5, 16'hFEC7, 16'hFEC8, 16'hFEC6};
      6'd25: f = '{16'hFEC9, 16'hFECB, 16'hFECC, 16'hFECA};
      6'd26: f = '{16'hFECD, 16'hFECF, 16'hFED0, 16'hFECE};
      6'd27: f = '{16'h0640, 16'h0640, 16'h0640, 16'h0640};
      6'd28: f = '{16'hFED1, 16'hFED3, 16'hFED4, 16'hFED2};
      6'd29: f = '{16'hFED5, 16'hFED7, 16'hFED8, 16'hFED6};
      6'd30: f = '{16'hFED9, 16'hFEDB, 16'hFEDC, 16'hFEDA};
      6'd31: f = '{16'hFEDD, 16'hFEDF, 16'hFEE0, 16'hFEDE};
      6'd32: f = '{16'hFEE1, 16'hFEE3, 16'hFEE4, 16'hFEE2};
      6'd33: f = '{16'hFEE5, 16'hFEE7, 16'hFEE8, 16'hFEE6};
      6'd34: f = '{16'hFEE9, 16'hFEEB, 16'hFEEC, 16'hFEEA};
      6'd35: f = '{16'hFEED, 16'h0000, 16'h0000, 16'hFEEE};
      6'd36: f = '{16'hFEEF, 16'hFBE8, 16'hFBE9, 16'hFBFD};
      6'd37: f = '{16'hFEF1, 16'hFEF3, 16'hFEF4, 16'hFEF2};
      6'd38: f = '{16'hFBFC, 16'hFBFE, 16'hFBFF, 16'hFEF0};
      6'd39: f = '{16'hFB7A, 16'hFB7C, 16'hFB7D, 16'hFB7B};
      6'd40: f = '{16'hFB56, 16'hFB58, 16'hFB59, 16'hFB57};
      6'd41: f = '{16'hFB92, 16'hFB94, 16'hFB95, 16'hFB93};
      6'd42: f = '{16'hFB8E, 16'hFB90, 16'hFB91, 16'hFB8F};
      default: f = '0;
    endcase
    return f;
  endfunction

  function automatic logic is_mark(input logic [15:0] cp);
    logic m;
    case (cp)
      16'h0610, 16'h0612, 16'h0613, 16'h0614, 16'h0615, 16'h064B, 16'h064C,
      16'h064D, 16'h064E, 16'h064F, 16'h0650, 16'h0651, 16'h0652, 16'h0653,
      16'h0654, 16'h0655, 16'h0656, 16'h0657, 16'h0658, 16'h0670, 16'h06D6,
      16'h06D7, 16'h06D8, 16'h06D9, 16'h06DA, 16'h06DB, 16'h06DC, 16'h06DF,
      16'h06E0, 16'h06E1, 16'h06E2, 16'h06E3, 16'h06E4, 16'h06E7, 16'h06E8,
      16'h06EA, 16'h06EB, 16'h06EC, 16'h06ED: m = 1'b1;
      default: m = 1'b0;
    endcase
    return m;
  endfunction

endpackage
`default_nettype wire

### design/acs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none
module acs_ram #(
  parameter int unsigned Width     = 16,
  parameter int unsigned Depth     = 16,
  parameter int unsigned AddrWidth = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire                 clk_i,
  input  wire                 we_i,
  input  wire [AddrWidth-1:0] waddr_i,
  input  wire [Width-1:0]     wdata_i,
  input  wire [AddrWidth-1:0] raddr_i,
  output logic [Width-1:0]    rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

### design/acs_datapath.sv
// Shaper datapath: input capture, held-letter context, mark queue, output register.
// Depends on acs_pkg and acs_ram.
`default_nettype none
module acs_datapath import acs_pkg::*; #(
  parameter int unsigned MarkQueueDepth = MarkQueueDepthDefault
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  in_word_t   in_word_i,
  input  ctrl_t      ctrl_i,
  output stat_t      stat_o,
  output out_word_t  out_word_o
);
  localparam int unsigned AW = (MarkQueueDepth > 1) ? $clog2(MarkQueueDepth) : 1;
  localparam int unsigned CW = $clog2(MarkQueueDepth + 1);

  logic [15:0] cp_q;
  logic        eot_q, letter_q, mark_q;
  logic [5:0]  row_q;
  logic        held_valid_q, held_prev_q, prior_q;
  logic [5:0]  held_row_q;
  logic [CW-1:0] count_q, rd_q;
  out_word_t   out_q;
  logic [15:0] rdata;
  forms_t      hf, cf;
  logic        join_prev, after;
  logic [15:0] form;
  logic [AW-1:0] waddr, raddr;

  assign cf = letter_forms(row_q);
  assign hf = letter_forms(held_row_q);

  // Capture and classify the accepted word.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      cp_q     <= in_word_i.code_point;
      eot_q    <= in_word_i.end_of_text;
      row_q    <= letter_row(in_word_i.code_point);
      letter_q <= (letter_row(in_word_i.code_point) != NoLetter);
      mark_q   <= is_mark(in_word_i.code_point);
    end
  end

  // Joining context and queue counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_valid_q <= 1'b0;
      held_prev_q  <= 1'b0;
      prior_q      <= 1'b0;
      held_row_q   <= '0;
      count_q      <= '0;
      rd_q         <= '0;
    end else begin
      if (ctrl_i.clear_held) begin
        held_valid_q <= 1'b0;
        count_q      <= '0;
      end
      if (ctrl_i.prior_clear) prior_q <= 1'b0;
      if (ctrl_i.hold_letter) begin
        held_valid_q <= 1'b1;
        held_row_q   <= row_q;
        held_prev_q  <= prior_q;
        prior_q      <= (cf.ini != '0) || (cf.med != '0);
        count_q      <= '0;
      end
      if (ctrl_i.enqueue) count_q <= count_q + 1'b1;
      if (ctrl_i.eot_clear) begin
        held_valid_q <= 1'b0;
        count_q      <= '0;
        prior_q      <= 1'b0;
        held_prev_q  <= 1'b0;
        held_row_q   <= '0;
      end
      // pointer starts from zero for every release
      if (ctrl_i.rd_start || ctrl_i.clear_held) rd_q <= '0;
      else if (ctrl_i.rd_next) rd_q <= rd_q + 1'b1;
    end
  end

  assign waddr = count_q[AW-1:0];
  // Read address looks one ahead so data is ready when the pointer steps.
  assign raddr = ctrl_i.rd_start ? '0 :
                 ctrl_i.rd_next ? AW'(rd_q + 1'b1) : rd_q[AW-1:0];

  acs_ram #(.Width(16), .Depth(MarkQueueDepth)) u_queue (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.enqueue),
    .waddr_i (waddr),
    .wdata_i (cp_q),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Form selection: medial, final, initial, isolated.
  always_comb begin
    join_prev = held_prev_q;
    after     = ctrl_i.after_join;
    if (join_prev && after && hf.med != '0) form = hf.med;
    else if (join_prev && hf.fin != '0)     form = hf.fin;
    else if (after && hf.ini != '0)         form = hf.ini;
    else                                    form = hf.iso;
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.emit) begin
      case (ctrl_i.src)
        SRC_LETTER: out_q.shaped_code <= form;
        SRC_MARK:   out_q.shaped_code <= rdata;
        SRC_INPUT:  out_q.shaped_code <= cp_q;
        default:    out_q.shaped_code <= cp_q;
      endcase
      out_q.last_of_run <= ctrl_i.last;
    end
  end
  assign out_word_o = out_q;

  assign stat_o.is_letter  = letter_q;
  assign stat_o.is_mark    = mark_q;
  assign stat_o.eot        = eot_q;
  assign stat_o.held_valid = held_valid_q;
  assign stat_o.queue_full = (count_q == CW'(MarkQueueDepth));
  assign stat_o.marks_left = (rd_q < count_q);
  assign stat_o.marks_one  = (rd_q + 1'b1 == count_q);
  assign stat_o.joins_bwd  = (cf.med != '0) || (cf.fin != '0);
endmodule
`default_nettype wire

### design/acs_ctrl.sv
// Shaper controller: sequences release of the held letter, its marks and passed words.
// Depends on acs_pkg.
`default_nettype none
module acs_ctrl import acs_pkg::*; (
  input  wire   clk_i,
  input  wire   rst_ni,
  input  wire   in_valid_i,
  output logic  in_stall_o,
  output logic  out_valid_o,
  input  wire   out_stall_i,
  input  stat_t stat_i,
  output ctrl_t ctrl_o
);
  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_DECIDE = 6'b000010,
    ST_LETTER = 6'b000100,
    ST_MARKS  = 6'b001000,
    ST_PASS   = 6'b010000,
    ST_WAIT   = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic after_q, after_d;     // join flag used for the held letter
  logic passing_q, passing_d; // the input word itself follows the release
  logic hold_q, hold_d;       // captured letter becomes held afterwards

  logic out_free;
  logic more;                 // further words follow this release
  assign out_free = !out_valid_q || !out_stall_i;
  assign more     = passing_q || (hold_q && stat_i.eot);

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    after_d     = after_q;
    passing_d   = passing_q;
    hold_d      = hold_q;
    ctrl_o      = '0;
    ctrl_o.src  = SRC_INPUT;
    ctrl_o.after_join = after_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          ctrl_o.capture = 1'b1;
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        hold_d    = stat_i.is_letter;
        passing_d = !stat_i.is_letter;
        after_d   = stat_i.is_letter && stat_i.joins_bwd;
        if (stat_i.is_mark && !stat_i.is_letter && stat_i.held_valid &&
            !stat_i.queue_full) begin
          // queue the mark; on end of text go on to release the held letter
          ctrl_o.enqueue = 1'b1;
          passing_d = 1'b0;
          after_d   = 1'b0;
          state_d   = stat_i.eot ? ST_WAIT : ST_IDLE;
        end else if (stat_i.held_valid) begin
          // a non-letter breaks the join on both sides
          if (!stat_i.is_letter) ctrl_o.prior_clear = 1'b1;
          state_d = ST_LETTER;
        end else begin
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        // after a decision or a release: hold the letter, pass the word, handle end of text
        if (hold_q) begin
          ctrl_o.hold_letter = 1'b1;
          hold_d = 1'b0;
          state_d = stat_i.eot ? ST_WAIT : ST_IDLE;
          // come back with hold cleared so end of text releases the new letter
          if (stat_i.eot) begin
            passing_d = 1'b0;
            after_d   = 1'b0;
          end
        end else if (passing_q) begin
          state_d = ST_PASS;
        end else if (stat_i.eot && stat_i.held_valid) begin
          after_d = 1'b0;
          state_d = ST_LETTER;
        end else begin
          if (stat_i.eot) ctrl_o.eot_clear = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_LETTER: begin
        ctrl_o.after_join = after_q;
        if (out_free) begin
          ctrl_o.emit     = 1'b1;
          ctrl_o.src      = SRC_LETTER;
          ctrl_o.rd_start = 1'b1;
          ctrl_o.last     = !stat_i.marks_left && !more;
          out_valid_d     = 1'b1;
          state_d = stat_i.marks_left ? ST_MARKS : ST_WAIT;
          if (!stat_i.marks_left) ctrl_o.clear_held = 1'b1;
        end
      end
      ST_MARKS: begin
        if (out_free) begin
          ctrl_o.emit    = 1'b1;
          ctrl_o.src     = SRC_MARK;
          ctrl_o.rd_next = 1'b1;
          ctrl_o.last    = stat_i.marks_one && !more;
          out_valid_d    = 1'b1;
          if (stat_i.marks_one) begin
            ctrl_o.clear_held = 1'b1;
            state_d = ST_WAIT;
          end
        end
      end
      ST_PASS: begin
        if (out_free) begin
          ctrl_o.emit        = 1'b1;
          ctrl_o.src         = SRC_INPUT;
          ctrl_o.last        = 1'b1;
          ctrl_o.prior_clear = stat_i.held_valid || !stat_i.is_mark;
          out_valid_d        = 1'b1;
          passing_d          = 1'b0;
          if (stat_i.eot) ctrl_o.eot_clear = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      after_q     <= 1'b0;
      passing_q   <= 1'b0;
      hold_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      after_q     <= after_d;
      passing_q   <= passing_d;
      hold_q      <= hold_d;
    end
  end
endmodule
`default_nettype wire

### design/arabic_contextual_shaper.sv
// Top level of the Arabic contextual shaper: controller plus datapath.
// Depends on acs_pkg, acs_ctrl, acs_datapath.
`default_nettype none
// Streams 16-bit code points in and presentation forms out. A letter is held
// until the next non-mark word shows whether it joins; marks behind it are
// queued (up to MarkQueueDepth). A new word is taken only while the sequencer
// is idle. A mark is queued after capture and classify; a letter with nothing
// held is captured, classified, then held; a word passed with nothing held is
// captured, classified and then sent. A release sends the held letter, then
// its queued marks, then any passed word. A mark that finds the queue full, or
// end of text, also releases the held letter. Results leave through one output
// register, so a sink stall holds back a waiting word.
module arabic_contextual_shaper import acs_pkg::*; #(
  parameter int unsigned MarkQueueDepth = MarkQueueDepthDefault
) (
  input  wire       clk_i,
  input  wire       rst_ni,
  input  wire       in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  wire       out_stall_i,
  output out_word_t out_word_o
);
  ctrl_t ctrl;
  stat_t stat;

  acs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  acs_datapath #(.MarkQueueDepth(MarkQueueDepth)) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_word_i  (in_word_i),
    .ctrl_i     (ctrl),
    .stat_o     (stat),
    .out_word_o (out_word_o)
  );
endmodule
`default_nettype wire

### test/arabic_contextual_shaper_tb.sv
// Self-checking testbench for arabic_contextual_shaper: directed table, then random text.
// Depends on acs_pkg and the arabic_contextual_shaper RTL.
`default_nettype none
module arabic_contextual_shaper_tb;
  import acs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QueueDepth = MarkQueueDepthDefault;
  localparam int unsigned StallLimit = 4000;
  localparam logic [15:0] NoCheck = 16'h0000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_word;

  arabic_contextual_shaper DUT (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_word_i(in_word),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_word_o(out_word)
  );

  // Letter table: letter code, isolated, initial, medial, final (0 = absent).
  logic [15:0] form_tbl [43][5] = '{
    '{16'h0621, 16'hFE80, 0, 0, 0},
    '{16'h0622, 16'hFE81, 0, 0, 16'hFE82},
    '{16'h0623, 16'hFE83, 0, 0, 16'hFE84},
    '{16'h0624, 16'hFE85, 0, 0, 16'hFE86},
    '{16'h0625, 16'hFE87, 0, 0, 16'hFE88},
    '{16'h0626, 16'hFE89, 16'hFE8B, 16'hFE8C, 16'hFE8A},
    '{16'h0627, 16'hFE8D, 0, 0, 16'hFE8E},
    '{16'h0628, 16'hFE8F, 16'hFE91, 16'hFE92, 16'hFE90},
    '{16'h0629, 16'hFE93, 0, 0, 16'hFE94},
    '{16'h062A, 16'hFE95, 16'hFE97, 16'hFE98, 16'hFE96},
    '{16'h062B, 16'hFE99, 16'hFE9B, 16'hFE9C, 16'hFE9A},
    '{16'h062C, 16'hFE9D, 16'hFE9F, 16'hFEA0, 16'hFE9E},
    '{16'h062D, 16'hFEA1, 16'hFEA3, 16'hFEA4, 16'hFEA2},
    '{16'h062E, 16'hFEA5, 16'hFEA7, 16'hFEA8, 16'hFEA6},
    '{16'h062F, 16'hFEA9, 0, 0, 16'hFEAA},
    '{16'h0630, 16'hFEAB, 0, 0, 16'hFEAC},
    '{16'h0631, 16'hFEAD, 0, 0, 16'hFEAE},
    '{16'h0632, 16'hFEAF, 0, 0, 16'hFEB0},
    '{16'h0698, 16'hFB8A, 0, 0, 16'hFB8B},
    '{16'h0633, 16'hFEB1, 16'hFEB3, 16'hFEB4, 16'hFEB2},
    '{16'h0634, 16'hFEB5, 16'hFEB7, 16'hFEB8, 16'hFEB6},
    '{16'h0635, 16'hFEB9, 16'hFEBB, 16'hFEBC, 16'hFEBA},
    '{16'h0636, 16'hFEBD, 16'hFEBF, 16'hFEC0, 16'hFEBE},
    '{16'h0637, 16'hFEC1, 16'hFEC3, 16'hFEC4, 16'hFEC2},
    '{16'h0638, 16'hFEC5, 16'hFEC7, 16'hFEC8, 16'hFEC6},
    '{16'h0639, 16'hFEC9, 16'hFECB, 16'hFECC, 16'hFECA},
    '{16'h063A, 16'hFECD, 16'hFECF, 16'hFED0, 16'hFECE},
    '{16'h0640, 16'h0640, 16'h0640, 16'h0640, 16'h0640},
    '{16'h0641, 16'hFED1, 16'hFED3, 16'hFED4, 16'hFED2},
    '{16'h0642, 16'hFED5, 16'hFED7, 16'hFED8, 16'hFED6},
    '{16'h0643, 16'hFED9, 16'hFEDB, 16'hFEDC, 16'hFEDA},
    '{16'h0644, 16'hFEDD, 16'hFEDF, 16'hFEE0, 16'hFEDE},
    '{16'h0645, 16'hFEE1, 16'hFEE3, 16'hFEE4, 16'hFEE2},
    '{16'h0646, 16'hFEE5, 16'hFEE7, 16'hFEE8, 16'hFEE6},
    '{16'h0647, 16'hFEE9, 16'hFEEB, 16'hFEEC, 16'hFEEA},
    '{16'h0648, 16'hFEED, 0, 0, 16'hFEEE},
    '{16'h0649, 16'hFEEF, 16'hFBE8, 16'hFBE9, 16'hFBFD},
    '{16'h064A, 16'hFEF1, 16'hFEF3, 16'hFEF4, 16'hFEF2},
    '{16'h06CC, 16'hFBFC, 16'hFBFE, 16'hFBFF, 16'hFEF0},
    '{16'h0686, 16'hFB7A, 16'hFB7C, 16'hFB7D, 16'hFB7B},
    '{16'h067E, 16'hFB56, 16'hFB58, 16'hFB59, 16'hFB57},
    '{16'h06AF, 16'hFB92, 16'hFB94, 16'hFB95, 16'hFB93},
    '{16'h06A9, 16'hFB8E, 16'hFB90, 16'hFB91, 16'hFB8F}
  };

  logic [15:0] mark_tbl [39] = '{
    16'h0610, 16'h0612, 16'h0613, 16'h0614, 16'h0615, 16'h064B, 16'h064C, 16'h064D,
    16'h064E, 16'h064F, 16'h0650, 16'h0651, 16'h0652, 16'h0653, 16'h0654, 16'h0655,
    16'h0656, 16'h0657, 16'h0658, 16'h0670, 16'h06D6, 16'h06D7, 16'h06D8, 16'h06D9,
    16'h06DA, 16'h06DB, 16'h06DC, 16'h06DF, 16'h06E0, 16'h06E1, 16'h06E2, 16'h06E3,
    16'h06E4, 16'h06E7, 16'h06E8, 16'h06EA, 16'h06EB, 16'h06EC, 16'h06ED
  };

  // Shaper state mirror.
  logic        sh_held;
  int          sh_row;
  logic        sh_prev_joins;
  logic        sh_prior_fwd;
  logic [15:0] sh_marks [$];

  out_word_t expected_words [$];
  int        mismatches;
  bit        quiet_tail;
  bit        timed_out;
  int        idle_cycles;

  function automatic int find_row(logic [15:0] cp);
    for (int r = 0; r < 43; r++) if (form_tbl[r][0] == cp) return r;
    return -1;
  endfunction

  function automatic bit mark_code(logic [15:0] cp);
    foreach (mark_tbl[k]) if (mark_tbl[k] == cp) return 1'b1;
    return 1'b0;
  endfunction

  function automatic bit fwd_join(int r);
    return r >= 0 && (form_tbl[r][2] != 0 || form_tbl[r][3] != 0);
  endfunction

  function automatic bit bwd_join(int r);
    return r >= 0 && (form_tbl[r][3] != 0 || form_tbl[r][4] != 0);
  endfunction

  function automatic logic [15:0] choose_form(int r, bit b, bit a);
    if (b && a && form_tbl[r][3] != 0) return form_tbl[r][3];
    if (b && form_tbl[r][4] != 0) return form_tbl[r][4];
    if (a && form_tbl[r][2] != 0) return form_tbl[r][2];
    return form_tbl[r][1];
  endfunction

  task automatic push_code(logic [15:0] c, inout int n);
    out_word_t w;
    w.shaped_code = c;
    w.last_of_run = 1'b0;
    expected_words.push_back(w);
    n++;
  endtask

  task automatic flush_held(bit after, inout int n);
    if (sh_held) begin
      push_code(choose_form(sh_row, sh_prev_joins, after), n);
      foreach (sh_marks[k]) push_code(sh_marks[k], n);
    end
    sh_held = 1'b0;
    sh_marks.delete();
  endtask

  // Predict the words caused by one input word; returns their count.
  task automatic shape_word(in_word_t w, output int n);
    int r;
    n = 0;
    r = find_row(w.code_point);
    if (r >= 0) begin
      flush_held(bwd_join(r), n);
      sh_held = 1'b1;
      sh_row = r;
      sh_prev_joins = sh_prior_fwd;
      sh_prior_fwd = fwd_join(r);
    end else if (mark_code(w.code_point)) begin
      if (!sh_held) push_code(w.code_point, n);
      else if (sh_marks.size() < QueueDepth) sh_marks.push_back(w.code_point);
      else begin
        flush_held(1'b0, n);
        push_code(w.code_point, n);
        sh_prior_fwd = 1'b0;
      end
    end else begin
      flush_held(1'b0, n);
      push_code(w.code_point, n);
      sh_prior_fwd = 1'b0;
    end
    if (w.end_of_text) begin
      flush_held(1'b0, n);
      sh_prior_fwd = 1'b0;
      sh_prev_joins = 1'b0;
      sh_row = 0;
    end
    if (n > 0) expected_words[$].last_of_run = 1'b1;
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Send one word with random leading gaps, then wait for acceptance.
  // Stall is looked at on the falling edge, where it holds for the next rise.
  task automatic send_word(logic [15:0] cp, logic eot, logic [15:0] first_code);
    in_word_t w;
    int n;
    w.code_point = cp;
    w.end_of_text = eot;
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    shape_word(w, n);
    // typed-in first result where it is obvious from the table
    if (first_code != NoCheck && n > 0 &&
        expected_words[expected_words.size() - n].shaped_code != first_code) begin
      mismatches++;
      if (mismatches <= 10)
        $display("directed row %h: table says %h, predictor %h", cp, first_code,
                 expected_words[expected_words.size() - n].shaped_code);
    end
  endtask

  task automatic random_text();
    int len;
    int pick;
    logic [15:0] cp;
    len = $urandom_range(1, 8);
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) cp = form_tbl[$urandom_range(0, 42)][0];
      else if (pick < 85) cp = mark_tbl[$urandom_range(0, 38)];
      else if (pick < 93) cp = 16'h0020;
      else cp = 16'($urandom());
      send_word(cp, (i == len - 1) ? 1'b1 : 1'($urandom_range(0, 15) == 0), NoCheck);
    end
  endtask

  typedef struct {
    logic [15:0] cp;
    logic        eot;
    logic [15:0] first_code;
  } dir_row_t;

  dir_row_t dir_rows [] = '{
    '{16'h0000, 1'b0, 16'h0000},
    '{16'hFFFF, 1'b1, 16'hFFFF},
    '{16'h0610, 1'b0, 16'h0610},
    '{16'h06ED, 1'b1, 16'h06ED},
    '{16'h0628, 1'b1, 16'hFE8F},
    '{16'h0628, 1'b0, NoCheck},
    '{16'h0628, 1'b0, 16'hFE91},
    '{16'h0628, 1'b0, 16'hFE92},
    '{16'h0621, 1'b0, 16'hFE90},
    '{16'h0627, 1'b0, 16'hFE80},
    '{16'h0020, 1'b0, 16'hFE8D},
    '{16'h06CC, 1'b0, NoCheck},
    '{16'h064B, 1'b0, NoCheck},
    '{16'h0640, 1'b0, 16'hFBFE},
    '{16'h06A9, 1'b1, 16'h0640},
    '{16'h5555, 1'b0, 16'h5555},
    '{16'hAAAA, 1'b1, 16'hAAAA}
  };

  // Stimulus
  initial begin
    int unsigned k;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_word = '0;
    mismatches = 0;
    quiet_tail = 1'b0;
    timed_out = 1'b0;
    sh_held = 1'b0;
    sh_row = 0;
    sh_prev_joins = 1'b0;
    sh_prior_fwd = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir_rows[i]) send_word(dir_rows[i].cp, dir_rows[i].eot, dir_rows[i].first_code);
    // full mark queue, then one more mark forces the release
    send_word(16'h0644, 1'b0, NoCheck);
    for (k = 0; k <= QueueDepth; k++) send_word(mark_tbl[k % 39], 1'b0, NoCheck);
    send_word(16'h0645, 1'b1, NoCheck);
    // pause until everything has drained
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    for (k = 0; k < 12; k++) random_text();
    quiet_tail = 1'b1;
    for (k = 0; k < 4; k++) random_text();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_words.size() != 0 && !timed_out) @(posedge clk);
    repeat (30) @(posedge clk);
    if (!timed_out) begin
      if (mismatches == 0 && expected_words.size() == 0)
        $display("arabic_contextual_shaper verification clean");
      else
        $display("arabic_contextual_shaper verification failed");
      $finish;
    end
  end

  // Sink stall bursts
  initial begin
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (!quiet_tail && !out_stall && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Result checker and watchdog
  always @(posedge clk) begin
    out_word_t exp_w;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        idle_cycles <= 0;
        if (expected_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word %h/%b", out_word.shaped_code,
                                         out_word.last_of_run);
        end else begin
          exp_w = expected_words.pop_front();
          if (exp_w.shaped_code != out_word.shaped_code ||
              exp_w.last_of_run != out_word.last_of_run) begin
            mismatches++;
            if (mismatches <= 10)
              $display("word mismatch: expected %h/%b actual %h/%b", exp_w.shaped_code,
                       exp_w.last_of_run, out_word.shaped_code, out_word.last_of_run);
          end
        end
      end else if (in_valid && !in_stall) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= StallLimit && !timed_out) begin
          timed_out = 1'b1;
          $display("arabic_contextual_shaper verification failed");
          $finish;
        end
      end
    end else begin
      idle_cycles <= 0;
    end
  end

endmodule
`default_nettype wire
